FILE: rtl/core/ddma_pkg.sv
// ----------------------------------------------------------------------------
// ddma_pkg: shared definitions for the dust density moving average core
// Field widths, conversion constants, controller state type and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ddma_pkg;

  // Field widths of the words on the ports.
  localparam int ADC_W  = 12;
  localparam int GAIN_W = 16;
  localparam int DENS_W = 17;

  // Conversion: base = floor(adc * 8978 / 4096), density = max(0, base - 1600).
  localparam int FRAC_W  = 12;
  localparam int SLOPE_W = 14;
  localparam int BASE_W  = ADC_W + SLOPE_W - FRAC_W;
  localparam int DIFF_W  = 13;

  localparam logic [SLOPE_W-1:0] SLOPE_NUM   = 14'd8978;
  localparam logic [BASE_W-1:0]  OFFSET_16TH = 14'd1600;
  localparam logic [DENS_W-1:0]  DENS_MAX    = 17'd131071;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;

  // Default window length.
  localparam int SAMPLES_DEFAULT = 16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SCALE,
    ST_UPDATE,
    ST_MEAN,
    ST_OUTPUT
  } ddma_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic calc_base;
    logic calc_scale;
    logic update;
    logic calc_mean;
    logic load_out;
  } ddma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } ddma_status_t;

endpackage

FILE: rtl/core/ddma_if.sv
// ----------------------------------------------------------------------------
// ddma_if: channel interfaces of the dust density moving average core
// Sample input channel, result output channel and calibration write channel,
// each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface ddma_in_if;
  import ddma_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADC_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ddma_out_if;
  import ddma_pkg::*;

  logic              valid;
  logic              ready;
  logic [DENS_W-1:0] raw_density;
  logic [DENS_W-1:0] mean_density;

  modport source (output valid, output raw_density, output mean_density, input ready);
  modport sink   (input valid, input raw_density, input mean_density, output ready);
endinterface

interface ddma_cfg_if;
  import ddma_pkg::*;

  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] calib_gain;

  modport source (output valid, output calib_gain, input ready);
  modport sink   (input valid, input calib_gain, output ready);
endinterface

FILE: rtl/core/ddma_ctrl.sv
// ----------------------------------------------------------------------------
// ddma_ctrl: sequencing controller
// Walks one sample word through conversion, scaling, window update, mean
// and output load, and holds the output step while the result is not taken.
// ----------------------------------------------------------------------------
module ddma_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ddma_pkg::ddma_status_t status,
  output ddma_pkg::ddma_cmd_t    cmd
);
  import ddma_pkg::*;

  ddma_state_t state;
  ddma_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_BASE;
      end
      ST_BASE:   state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_MEAN;
      ST_MEAN:   state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (!status.out_blocked) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands and input handshake; no word is taken while in reset.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = !rst;
        cmd.load_sample = in_valid && !rst;
      end
      ST_BASE:   cmd.calc_base  = 1'b1;
      ST_SCALE:  cmd.calc_scale = 1'b1;
      ST_UPDATE: cmd.update     = 1'b1;
      ST_MEAN:   cmd.calc_mean  = 1'b1;
      ST_OUTPUT: cmd.load_out   = !status.out_blocked;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/ddma_datapath.sv
// ----------------------------------------------------------------------------
// ddma_datapath: conversion, window ring and mean datapath
// Converts a sample to density, applies the calibration gain, keeps the
// ring of recent densities with its running sum and forms the window mean
// by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module ddma_datapath #(
  parameter int SAMPLES = ddma_pkg::SAMPLES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ddma_pkg::ddma_cmd_t        cmd,
  output ddma_pkg::ddma_status_t     status,
  input  logic [ddma_pkg::ADC_W-1:0] adc_sample,
  ddma_cfg_if.sink                   cfg,
  ddma_out_if.source                 result_out
);
  import ddma_pkg::*;

  localparam int PTR_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int LOG_N  = $clog2(SAMPLES);
  localparam int SUM_W  = DENS_W + LOG_N;
  localparam int SHIFT  = SUM_W + LOG_N;
  // Rounded-up reciprocal: exact floor(sum / SAMPLES) for every sum below
  // 2**SUM_W, since the rounding error times the sum stays below 2**SHIFT.
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(SAMPLES) - 64'd1) / longint'(SAMPLES);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned SUM_MAX = longint'(SAMPLES) * 64'd131071;

  localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
  localparam logic [PTR_W-1:0]   LAST_POS = PTR_W'(SAMPLES - 1);

  // Registers.
  logic [GAIN_W-1:0]  gain;
  logic [ADC_W-1:0]   adc_q;
  logic [DIFF_W-1:0]  diff_q;
  logic [DENS_W-1:0]  dens_q;
  logic [DENS_W-1:0]  ring_q;
  logic [SAMPLES-1:0] ring_valid;
  logic [PTR_W-1:0]   wpos;
  logic [SUM_W-1:0]   wsum;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid;
  logic [DENS_W-1:0]  out_raw;
  logic [DENS_W-1:0]  out_mean;

  logic [DENS_W-1:0]  ring_mem [SAMPLES];

  // Combinational terms.
  logic [ADC_W+SLOPE_W-1:0] slope_prod;
  logic [BASE_W-1:0]        base;
  logic [DIFF_W-1:0]        diff_next;
  logic [DIFF_W+GAIN_W-1:0] scale_prod;
  logic [DENS_W-1:0]        oldest;
  logic [SUM_W-1:0]         wsum_next;
  logic [PTR_W-1:0]         wpos_next;

  // Calibration register; writes are taken whenever out of reset.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg.valid) begin
      gain <= cfg.calib_gain;
    end
  end

  // Linear conversion with the offset folded into a zero clamp.
  assign slope_prod = adc_q * SLOPE_NUM;
  assign base       = slope_prod[ADC_W+SLOPE_W-1:FRAC_W];
  assign diff_next  = (base > OFFSET_16TH) ? DIFF_W'(base - OFFSET_16TH) : '0;

  // Gain scaling; the largest product shifted by 12 fits below DENS_MAX.
  assign scale_prod = diff_q * gain;

  // The entry about to be replaced reads as zero until it has been written.
  assign oldest    = ring_valid[wpos] ? ring_q : '0;
  assign wsum_next = wsum - SUM_W'(oldest) + SUM_W'(dens_q);
  assign wpos_next = (wpos == LAST_POS) ? '0 : wpos + PTR_W'(1);

  // Conversion pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) adc_q  <= adc_sample;
    if (cmd.calc_base)   diff_q <= diff_next;
    if (cmd.calc_scale)  dens_q <= scale_prod[DIFF_W+GAIN_W-1:FRAC_W];
    if (cmd.calc_mean)   prod_q <= wsum * RECIP_C;
  end

  // Ring memory, read at the write position with registered data.
  always_ff @(posedge clk) begin
    ring_q <= ring_mem[wpos];
    if (cmd.update) ring_mem[wpos] <= dens_q;
  end

  // Window control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      wpos       <= '0;
      wsum       <= '0;
    end else if (cmd.update) begin
      ring_valid[wpos] <= 1'b1;
      wpos             <= wpos_next;
      wsum             <= wsum_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_raw  <= dens_q;
      out_mean <= prod_q[SHIFT +: DENS_W];
    end
  end

  assign status.out_blocked     = out_valid && !result_out.ready;
  assign result_out.valid       = out_valid;
  assign result_out.raw_density = out_raw;
  assign result_out.mean_density = out_mean;

`ifndef SYNTHESIS
  // The running sum never exceeds a full window of saturated densities.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    64'(wsum) <= SUM_MAX)
    else $error("window sum beyond a full window of maximum densities");

  // The write position stays inside the ring.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(wpos) < SAMPLES)
    else $error("ring write position out of range");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |-> !cmd.load_out)
    else $error("output word overwritten before it was taken");

  // The mean product never carries bits above the density width.
  a_mean_width: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (prod_q >> SHIFT) == PROD_W'(prod_q[SHIFT +: DENS_W]))
    else $error("window mean wider than a density");

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/core/dust_density_moving_average_core.sv
// ----------------------------------------------------------------------------
// dust_density_moving_average_core: optical dust sensor density with mean
// Each 12-bit converter word on sample_in becomes a dust density in units of
// 1/16 ug/m3, max(0, floor(adc * 8978 / 4096) - 1600), scaled by the Q4.12
// calibration gain written on cfg (reset 1.0). The density replaces the
// oldest entry of a SAMPLES-entry ring, empty at reset so the mean ramps up,
// and result_out carries the raw density with the truncated window mean.
// One word is in flight at a time: the next word is accepted only after
// the controller has taken the last one through its five steps
// (conversion multiply, gain multiply, ring read and sum update,
// reciprocal multiply for the mean, output load). A result waiting on
// result_out does not stop a new word from being accepted; it only holds
// the output step. Gain writes are taken in any cycle out of reset.
// ----------------------------------------------------------------------------
module dust_density_moving_average_core #(
  parameter int SAMPLES = ddma_pkg::SAMPLES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  ddma_in_if.sink    sample_in,
  ddma_out_if.source result_out,
  ddma_cfg_if.sink   cfg
);
  import ddma_pkg::*;

  ddma_cmd_t    cmd;
  ddma_status_t status;

  // Sequencing controller.
  ddma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion, ring and mean datapath.
  ddma_datapath #(
    .SAMPLES (SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .adc_sample (sample_in.adc_sample),
    .cfg        (cfg),
    .result_out (result_out)
  );

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the dust density moving average core
// Converter words go in through a burst driver and results come back through
// a stalling monitor. Each accepted word updates a local density window, and
// every returned raw density and window mean is compared with that
// prediction. The calibration gain is changed between drained phases,
// including both ends of its range.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddma_pkg::*;

  localparam int          WINDOW      = SAMPLES_DEFAULT;
  localparam int unsigned CONV_SLOPE  = 8978;
  localparam int unsigned CONV_OFFSET = 1600;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 250;
  localparam int          DRAIN_WAIT  = 16;

  // Field extremes, the zero threshold and a ramping window at reset gain.
  localparam logic [ADC_W-1:0] CORNER_ADC [18] = '{
    12'd0, 12'd4095, 12'd729, 12'd730, 12'd731, 12'd732, 12'd1,
    12'd4094, 12'hAAA, 12'h555, 12'd2048, 12'd4095, 12'd4095,
    12'd1024, 12'd3000, 12'd800, 12'd4095, 12'd0
  };

  typedef struct {
    logic [DENS_W-1:0] raw;
    logic [DENS_W-1:0] mean;
  } density_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ddma_in_if  sample_if ();
  ddma_out_if result_if ();
  ddma_cfg_if gain_if ();

  dust_density_moving_average_core #(
    .SAMPLES(WINDOW)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_if),
    .result_out(result_if),
    .cfg       (gain_if)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting to be sent and density pairs waiting to come back.
  logic [ADC_W-1:0] adc_queue[$];
  density_pair_t    density_due[$];

  // Local copy of the gain and the density window.
  logic [GAIN_W-1:0] model_gain;
  logic [DENS_W-1:0] ring [WINDOW];
  int                wr_pos;
  logic [20:0]       window_sum;

  int mismatches;
  int words_taken;
  int cycles;

  // Density of one converter word at the given gain, clamped and saturated.
  function automatic logic [DENS_W-1:0] density_of(input logic [ADC_W-1:0] adc,
                                                   input logic [GAIN_W-1:0] gain);
    int unsigned      base;
    longint unsigned  scaled;
    base = (32'(adc) * CONV_SLOPE) >> 12;
    if (base <= CONV_OFFSET) return '0;
    scaled = (64'(base - CONV_OFFSET) * 64'(gain)) >> 12;
    if (scaled > 64'(DENS_MAX)) return DENS_MAX;
    return DENS_W'(scaled);
  endfunction

  // Insert a new density into the window and queue the pair it produces.
  task automatic take_sample(input logic [ADC_W-1:0] adc);
    logic [DENS_W-1:0] dens;
    dens = density_of(adc, model_gain);
    window_sum = window_sum - ring[wr_pos] + dens;
    ring[wr_pos] = dens;
    wr_pos = (wr_pos + 1) % WINDOW;
    density_due.push_back('{raw: dens, mean: DENS_W'(window_sum / WINDOW)});
  endtask

  // Random converter word, weighted towards the zero threshold and the top.
  function automatic logic [ADC_W-1:0] pick_adc();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return ADC_W'($urandom_range(0, 4095));
    if (sel < 8) return ADC_W'($urandom_range(700, 800));
    return ADC_W'($urandom_range(3500, 4095));
  endfunction

  // Sender: bursts of words with random gaps, prediction on acceptance.
  int  burst_left;
  int  gap_left;
  logic word_taken;

  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      word_taken = sample_if.valid && sample_if.ready;
      if (word_taken) begin
        take_sample(sample_if.adc_sample);
        words_taken <= words_taken + 1;
      end
      if (!sample_if.valid || word_taken) begin
        if (gap_left != 0) begin
          gap_left        <= gap_left - 1;
          sample_if.valid <= 1'b0;
        end else if (adc_queue.size() != 0) begin
          sample_if.valid      <= 1'b1;
          sample_if.adc_sample <= adc_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, twice, so that the core fills and stalls its input.
  int hold_left;
  int holds_done;

  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && words_taken >= 200) ||
                 (holds_done == 1 && words_taken >= 450)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: stall mode is redrawn each time stall_tick wraps, checks each returned word.
  logic [5:0]  stall_tick;
  int          stall_mode;
  logic [15:0] stall_pattern;
  logic        want_ready;
  density_pair_t due;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_tick      <= '0;
      stall_mode      <= 0;
      stall_pattern   <= 16'hffff;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (density_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: raw %0d mean %0d",
                     result_if.raw_density, result_if.mean_density);
        end else begin
          due = density_due.pop_front();
          if (result_if.raw_density !== due.raw || result_if.mean_density !== due.mean) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: raw exp %0d got %0d, mean exp %0d got %0d",
                       due.raw, result_if.raw_density, due.mean, result_if.mean_density);
          end
        end
      end
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == 6'd63) begin
        stall_mode    <= $urandom_range(0, 2);
        stall_pattern <= 16'($urandom) | 16'h0001;
      end
      case (stall_mode)
        0:       want_ready = 1'b1;
        1:       want_ready = 1'($urandom_range(0, 1));
        default: want_ready = stall_pattern[stall_tick[3:0]];
      endcase
      result_if.ready <= want_ready && (hold_left == 0);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Gain write, issued only while the core is idle; the core itself does not enforce this.
  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    gain_if.valid      <= 1'b1;
    gain_if.calib_gain <= gain;
    do @(posedge clk); while (!gain_if.ready);
    gain_if.valid <= 1'b0;
    model_gain = gain;
  endtask

  // Wait until every queued word has gone in and every result has come back.
  task automatic wait_drained();
    while (adc_queue.size() != 0 || sample_if.valid || density_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) adc_queue.push_back(pick_adc());
  endtask

  // Test sequence.
  initial begin
    mismatches           = 0;
    words_taken          = 0;
    cycles               = 0;
    model_gain           = GAIN_RESET;
    wr_pos               = 0;
    window_sum           = '0;
    foreach (ring[i]) ring[i] = '0;
    sample_if.valid      = 1'b0;
    sample_if.adc_sample = '0;
    result_if.ready      = 1'b0;
    gain_if.valid        = 1'b0;
    gain_if.calib_gain   = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset gain: field extremes, the zero threshold and the ramping window.
    for (int i = 0; i < $size(CORNER_ADC); i++)
      adc_queue.push_back(CORNER_ADC[i]);
    wait_drained();

    // Largest gain: the biggest product the fields allow.
    write_gain(16'hFFFF);
    adc_queue.push_back(12'd4095);
    adc_queue.push_back(12'd4095);
    adc_queue.push_back(12'd731);
    adc_queue.push_back(12'd730);
    adc_queue.push_back(12'd0);
    queue_random(100);
    wait_drained();

    // Zero gain: every density is zero and the mean decays to zero.
    write_gain('0);
    queue_random(60);
    wait_drained();

    write_gain(GAIN_W'($urandom_range(0, 65535)));
    queue_random(150);
    wait_drained();

    write_gain(16'd1);
    queue_random(40);
    wait_drained();

    write_gain(GAIN_W'($urandom_range(2048, 8192)));
    queue_random(150);
    wait_drained();

    write_gain(GAIN_RESET);
    queue_random(100);
    wait_drained();

    if (mismatches == 0 && density_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: dust_density_moving_average_core.f
rtl/core/ddma_pkg.sv
rtl/core/ddma_if.sv
rtl/core/ddma_ctrl.sv
rtl/core/ddma_datapath.sv
rtl/core/dust_density_moving_average_core.sv
sim/tb.sv
